/* src/pibs_pkg.sv */
// Package for the point-in-box table search unit: sizes, codes and types.
// Used by the interfaces, the box memory and the top level. No dependencies.
package pibs_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 32;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int IDX_BITS   = 6;
  localparam int COUNT_BITS = 7;
  localparam int RES_BITS   = 8;

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_BOXES);
  localparam logic [RES_BITS-1:0]   NO_BOX    = 8'hFF;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic        [SIZE_BITS-1:0]  size_x;
    logic        [SIZE_BITS-1:0]  size_y;
    logic        [SIZE_BITS-1:0]  size_z;
  } box_t;

endpackage

/* src/pibs_if.sv */
// Channel interfaces of the point-in-box table search unit: request, result
// and configuration write. Depends on pibs_pkg.
interface pibs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [pibs_pkg::IDX_BITS-1:0]          entry_index;
  logic signed [pibs_pkg::COORD_BITS-1:0] corner_x;
  logic signed [pibs_pkg::COORD_BITS-1:0] corner_y;
  logic signed [pibs_pkg::COORD_BITS-1:0] corner_z;
  logic [pibs_pkg::SIZE_BITS-1:0]         extent_x;
  logic [pibs_pkg::SIZE_BITS-1:0]         extent_y;
  logic [pibs_pkg::SIZE_BITS-1:0]         extent_z;
  logic signed [pibs_pkg::COORD_BITS-1:0] point_x;
  logic signed [pibs_pkg::COORD_BITS-1:0] point_y;
  logic signed [pibs_pkg::COORD_BITS-1:0] point_z;

  modport source (output valid, command, entry_index, corner_x, corner_y, corner_z,
                  extent_x, extent_y, extent_z, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, command, entry_index, corner_x, corner_y, corner_z,
                  extent_x, extent_y, extent_z, point_x, point_y, point_z,
                  output ready);
endinterface

interface pibs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [pibs_pkg::RES_BITS-1:0] box_index;

  modport source (output valid, found, box_index, input ready);
  modport sink   (input valid, found, box_index, output ready);
endinterface

interface pibs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pibs_pkg::COUNT_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/pibs_box_mem.sv */
// Box table memory: one write port, one read port, registered read data.
// Depends on pibs_pkg.
module pibs_box_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [pibs_pkg::IDX_BITS-1:0] wr_addr,
  input  pibs_pkg::box_t                wr_data,
  input  logic                          rd_en,
  input  logic [pibs_pkg::IDX_BITS-1:0] rd_addr,
  output pibs_pkg::box_t                rd_data
);

  pibs_pkg::box_t mem [pibs_pkg::MAX_BOXES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/point_in_box_table_search_unit.sv */
// Point-in-box table search unit. A load is accepted in idle and writes
// one table entry. A query scans one entry per cycle from the box memory
// and ends at the first hit, or when min(entry_count, 64) entries are
// searched without a hit; with entry_count zero it skips the scan.
// One item at a time: a new request is taken only in idle, after the previous
// result has been registered. Reset clears the control state, the result
// valid flag and entry_count; table contents stay undefined until loaded.
module point_in_box_table_search_unit (
  input  logic       clk,
  input  logic       rst,
  pibs_in_if.sink    in_req,
  pibs_out_if.source res,
  pibs_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                            state;
  logic [pibs_pkg::COUNT_BITS-1:0]   entry_count;
  logic [pibs_pkg::COUNT_BITS-1:0]   limit;
  logic [pibs_pkg::IDX_BITS-1:0]     cur;
  logic signed [pibs_pkg::COORD_BITS-1:0] pt_x, pt_y, pt_z;
  logic                              hit_found;
  logic [pibs_pkg::RES_BITS-1:0]     hit_index;

  logic                              out_valid;
  logic                              out_found;
  logic [pibs_pkg::RES_BITS-1:0]     out_index;

  logic                              accept;
  logic                              mem_wr;
  logic                              mem_rd;
  logic [pibs_pkg::IDX_BITS-1:0]     rd_addr;
  pibs_pkg::box_t                    wr_box;
  pibs_pkg::box_t                    rd_box;
  logic                              box_hit;
  logic                              last_entry;
  logic                              out_free;
  logic [pibs_pkg::COUNT_BITS-1:0]   count_lim;
  logic [pibs_pkg::IDX_BITS-1:0]     cur_next;

  function automatic logic axis_holds(
    input logic signed [pibs_pkg::COORD_BITS-1:0] lo,
    input logic        [pibs_pkg::SIZE_BITS-1:0]  size,
    input logic signed [pibs_pkg::COORD_BITS-1:0] p
  );
    logic signed [pibs_pkg::COORD_BITS:0] hi;
    logic signed [pibs_pkg::COORD_BITS:0] p_w;
    hi  = $signed({lo[pibs_pkg::COORD_BITS-1], lo}) + $signed({2'b00, size});
    p_w = $signed({p[pibs_pkg::COORD_BITS-1], p});
    return (lo <= p) && (p_w <= hi);
  endfunction

  assign in_req.ready = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;
  assign accept       = in_req.valid && in_req.ready;
  assign mem_wr       = accept && (in_req.command == pibs_pkg::CMD_LOAD);

  assign wr_box.min_x  = in_req.corner_x;
  assign wr_box.min_y  = in_req.corner_y;
  assign wr_box.min_z  = in_req.corner_z;
  assign wr_box.size_x = in_req.extent_x;
  assign wr_box.size_y = in_req.extent_y;
  assign wr_box.size_z = in_req.extent_z;

  // read entry 0 while idle, then run one entry ahead of the compare
  assign cur_next = cur + pibs_pkg::IDX_BITS'(1);
  assign rd_addr  = (state == ST_SCAN) ? cur_next : '0;
  assign mem_rd   = (state == ST_IDLE) || (state == ST_SCAN);

  pibs_box_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (in_req.entry_index),
    .wr_data (wr_box),
    .rd_en   (mem_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_box)
  );

  assign box_hit = axis_holds(rd_box.min_x, rd_box.size_x, pt_x) &&
                   axis_holds(rd_box.min_y, rd_box.size_y, pt_y) &&
                   axis_holds(rd_box.min_z, rd_box.size_z, pt_z);

  assign last_entry = ({1'b0, cur} + pibs_pkg::COUNT_BITS'(1)) == limit;
  assign count_lim  = (entry_count > pibs_pkg::MAX_COUNT) ? pibs_pkg::MAX_COUNT
                                                          : entry_count;
  assign out_free   = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      entry_count <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && in_req.command == pibs_pkg::CMD_QUERY) begin
            state <= (count_lim == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (box_hit || last_entry) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query context and scan result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pt_x      <= in_req.point_x;
        pt_y      <= in_req.point_y;
        pt_z      <= in_req.point_z;
        limit     <= count_lim;
        cur       <= '0;
        hit_found <= 1'b0;
        hit_index <= pibs_pkg::NO_BOX;
      end
      ST_SCAN: begin
        cur <= cur_next;
        if (box_hit) begin
          hit_found <= 1'b1;
          hit_index <= pibs_pkg::RES_BITS'(cur);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_found <= hit_found;
      out_index <= hit_index;
    end
  end

  assign res.valid     = out_valid;
  assign res.found     = out_found;
  assign res.box_index = out_index;

endmodule
